FILE: rtl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and character helpers of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef logic [1:0] code_t;
  typedef logic [1:0] kind_t;
  typedef logic [7:0] char_t;

  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam kind_t KIND_BALANCED = 2'd0;
  localparam kind_t KIND_BAD      = 2'd1;
  localparam kind_t KIND_MISSING  = 2'd2;
  localparam kind_t KIND_OVERFLOW = 2'd3;

  localparam code_t CODE_PAREN   = 2'd0;
  localparam code_t CODE_BRACE   = 2'd1;
  localparam code_t CODE_BRACKET = 2'd2;

  localparam char_t CH_OPEN_PAREN    = 8'h28;
  localparam char_t CH_OPEN_BRACE    = 8'h7B;
  localparam char_t CH_OPEN_BRACKET  = 8'h5B;
  localparam char_t CH_CLOSE_PAREN   = 8'h29;
  localparam char_t CH_CLOSE_BRACE   = 8'h7D;
  localparam char_t CH_CLOSE_BRACKET = 8'h5D;

  localparam logic [15:0] POS_FIELD_MAX = 16'hFFFF;

  function automatic logic is_opener(input char_t c);
    return (c == CH_OPEN_PAREN) || (c == CH_OPEN_BRACE) || (c == CH_OPEN_BRACKET);
  endfunction

  function automatic logic is_closer(input char_t c);
    return (c == CH_CLOSE_PAREN) || (c == CH_CLOSE_BRACE) || (c == CH_CLOSE_BRACKET);
  endfunction

  function automatic code_t opener_code(input char_t c);
    code_t r;
    r = CODE_BRACKET;
    if (c == CH_OPEN_PAREN) begin
      r = CODE_PAREN;
    end else if (c == CH_OPEN_BRACE) begin
      r = CODE_BRACE;
    end
    return r;
  endfunction

  function automatic char_t closer_char(input code_t code);
    char_t r;
    unique case (code)
      CODE_PAREN:   r = CH_CLOSE_PAREN;
      CODE_BRACE:   r = CH_CLOSE_BRACE;
      CODE_BRACKET: r = CH_CLOSE_BRACKET;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/bbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channels of the bracket balance checker: text in, report out.
// ----------------------------------------------------------------------------
interface bbc_text_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

interface bbc_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] position;
  logic [7:0]  char_out;
  logic        last;

  modport source (output valid, output kind, output position, output char_out,
                  output last, input ready);
  modport sink (input valid, input kind, input position, input char_out,
                input last, output ready);
endinterface

FILE: rtl/bracket_balance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks that ( ) { } [ ] in a byte stream are balanced and properly nested.
//
// The text channel carries one beat per byte (func = text) or an end beat
// (func = end). The report channel carries result beats: kind, position,
// char_out and last. A bad closer or a stack overflow gives one beat in the
// cycle after the offending byte; later bytes are counted but ignored until
// the end beat. An end beat on balanced text gives one balanced beat; with
// openers left it drains the stack top to bottom, one missing closer per
// cycle while the receiver takes them, the last marked. Text bytes are taken
// one per cycle while text.ready is high; the rate is set by the single read
// port of the stack memory, whose top entry is read ahead and forwarded.
// The report channel has one output register; the block takes a new beat
// while that register is empty or being taken, so a stalled receiver stops
// the text channel. Reset clears the counters and flags; the stack memory is
// not cleared and only entries written since the last reset are read.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int POS_BITS    = 16
) (
  input logic          clk,
  input logic          rst,
  bbc_text_if.sink     text,
  bbc_report_if.source report
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PW = (POS_BITS > 16) ? POS_BITS : 16;
  localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

  logic [CW-1:0]       count, count_next;
  logic [POS_BITS-1:0] idx, idx_next;
  logic                failed, failed_next;
  logic                draining, draining_next;

  logic        o_valid;
  kind_t       o_kind;
  logic [15:0] o_pos;
  char_t       o_char;
  logic        o_last;

  logic        out_free, accept, load;
  kind_t       kind_n;
  logic [15:0] pos_n, pos_sat;
  char_t       char_n;
  logic        last_n;
  logic [PW-1:0] pos_ext;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  code_t         wdata, top;

  bbc_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (top)
  );

  assign out_free   = !o_valid || report.ready;
  assign text.ready = !draining && out_free;
  assign accept     = text.valid && text.ready;

  assign pos_ext = PW'(idx);
  assign pos_sat = (pos_ext > PW'(POS_FIELD_MAX)) ? POS_FIELD_MAX : pos_ext[15:0];

  always_comb begin
    count_next    = count;
    idx_next      = idx;
    failed_next   = failed;
    draining_next = draining;
    load          = 1'b0;
    kind_n        = KIND_BALANCED;
    pos_n         = pos_sat;
    char_n        = '0;
    last_n        = 1'b1;
    we            = 1'b0;
    waddr         = AW'(count);
    wdata         = opener_code(text.ch);
    if (draining) begin
      if (out_free) begin
        load       = 1'b1;
        kind_n     = KIND_MISSING;
        char_n     = closer_char(top);
        last_n     = (count == CW'(1));
        count_next = count - 1'b1;
        if (count == CW'(1)) begin
          draining_next = 1'b0;
          idx_next      = '0;
          failed_next   = 1'b0;
        end
      end
    end else if (accept) begin
      if (text.func == FUNC_END) begin
        if (!failed && (count != '0)) begin
          draining_next = 1'b1;
        end else begin
          load        = !failed;
          pos_n       = '0;
          count_next  = '0;
          idx_next    = '0;
          failed_next = 1'b0;
        end
      end else begin
        if (idx != '1) begin
          idx_next = idx + 1'b1;
        end
        if (!failed) begin
          if (is_opener(text.ch)) begin
            if (count == COUNT_FULL) begin
              load        = 1'b1;
              kind_n      = KIND_OVERFLOW;
              char_n      = text.ch;
              failed_next = 1'b1;
            end else begin
              we         = 1'b1;
              count_next = count + 1'b1;
            end
          end else if (is_closer(text.ch)) begin
            if (count != '0) begin
              count_next = count - 1'b1;
            end
            if ((count == '0) || (closer_char(top) != text.ch)) begin
              load        = 1'b1;
              kind_n      = KIND_BAD;
              char_n      = text.ch;
              failed_next = 1'b1;
            end
          end
        end
      end
    end
  end

  assign raddr = (count_next == '0) ? '0 : AW'(count_next - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      failed   <= 1'b0;
      draining <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      count    <= count_next;
      idx      <= idx_next;
      failed   <= failed_next;
      draining <= draining_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (report.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_kind <= kind_n;
      o_pos  <= pos_n;
      o_char <= char_n;
      o_last <= last_n;
    end
  end

  assign report.valid    = o_valid;
  assign report.kind     = o_kind;
  assign report.position = o_pos;
  assign report.char_out = o_char;
  assign report.last     = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("stack count beyond depth");

  a_failed_no_push: assert property (@(posedge clk) disable iff (rst)
    failed |=> count <= $past(count))
    else $error("stack grew after a failure");

  a_end_failed_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (text.func == FUNC_END) && failed) |=>
      (!draining && !failed && (count == '0) && !o_valid))
    else $error("end beat after failure did not clear state");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (draining && out_free) |=> (count == CW'($past(count) - 1'b1)) && o_valid)
    else $error("drain did not pop one entry");

endmodule

FILE: rtl/bbc_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_stack_mem
// Opener stack memory with one write port and a registered read port that
// forwards a write to the entry being read.
// ----------------------------------------------------------------------------
module bbc_stack_mem
  import bbc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  code_t         wdata,
  input  logic [AW-1:0] raddr,
  output code_t         rdata
);

  code_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
